// ===== rtl/core/lkvc_pkg.sv =====
// lkvc_pkg: shared constants, types and sequencer states for the LRU key/value cache.
// No dependencies; used by every file under rtl/core.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESP,
        ST_INSERT
    } t_state;

    // control from the sequencer to the key/data store
    typedef struct packed {
        logic              key_we;
        logic              data_we;
        logic [IDX_W-1:0]  waddr;
        logic [KEY_W-1:0]  key_wdata;
        logic [DATA_W-1:0] data_wdata;
        logic [IDX_W-1:0]  key_raddr;
        logic [IDX_W-1:0]  data_raddr;
    } t_store_ctl;

endpackage

// ===== rtl/core/lkvc_kv_store.sv =====
// lkvc_kv_store: key and data memories of the cache, one write port each,
// one registered read port each. Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_kv_store (
    input  logic                       i_clk,
    input  lkvc_pkg::t_store_ctl       i_ctl,
    output logic [lkvc_pkg::KEY_W-1:0]  o_key_q,
    output logic [lkvc_pkg::DATA_W-1:0] o_data_q
);

    logic [lkvc_pkg::KEY_W-1:0]  r_key_mem  [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::DATA_W-1:0] r_data_mem [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::KEY_W-1:0]  r_key_q;
    logic [lkvc_pkg::DATA_W-1:0] r_data_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.key_we) begin
            r_key_mem[i_ctl.waddr] <= i_ctl.key_wdata;
        end
        if (i_ctl.data_we) begin
            r_data_mem[i_ctl.waddr] <= i_ctl.data_wdata;
        end
        r_key_q  <= r_key_mem[i_ctl.key_raddr];
        r_data_q <= r_data_mem[i_ctl.data_raddr];
    end

    assign o_key_q  = r_key_q;
    assign o_data_q = r_data_q;

endmodule

// ===== rtl/core/lru_key_value_cache_top.sv =====
// A get shows its result (hit flag and value) on the output handshake; puts give no result.
// One transaction at a time: a new one is taken only back in the idle step; the key scan
// runs through the single key memory read port and comparator.
// A pending result that is not taken holds the sequencer in its response step.
// Reset (i_rst_n low, synchronous): store empty, capacity 16, no result pending.
// Depends on lkvc_pkg and lkvc_kv_store.
`timescale 1ns / 1ps

module lru_key_value_cache_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_opcode,
    input  logic signed [lkvc_pkg::KEY_W-1:0]  i_lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_store_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_read_value,
    input  logic                               i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]         i_cfg_wdata
);

    lkvc_pkg::t_state r_state, n_state;

    logic [lkvc_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_cmp_vld;
    logic [lkvc_pkg::IDX_W-1:0]  r_cmp_idx;
    lkvc_pkg::t_opcode           r_op;
    logic [lkvc_pkg::KEY_W-1:0]  r_key;
    logic [lkvc_pkg::DATA_W-1:0] r_val;
    logic                        r_found;
    logic [lkvc_pkg::IDX_W-1:0]  r_hit_idx;
    logic                        r_vfound;
    logic [lkvc_pkg::IDX_W-1:0]  r_victim;
    logic [lkvc_pkg::IDX_W-1:0]  r_best;
    logic                        r_valid [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::IDX_W-1:0]  r_rec   [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::CNT_W-1:0]  r_fill;
    logic [lkvc_pkg::CAP_W-1:0]  r_cap;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [lkvc_pkg::DATA_W-1:0] r_out_value;

    lkvc_pkg::t_store_ctl        w_ctl;
    logic [lkvc_pkg::KEY_W-1:0]  w_key_q;
    logic [lkvc_pkg::DATA_W-1:0] w_data_q;
    logic [lkvc_pkg::CNT_W-1:0]  w_eff_cap;
    logic                        w_free_found;
    logic [lkvc_pkg::IDX_W-1:0]  w_free_idx;
    logic [lkvc_pkg::IDX_W-1:0]  w_hit_rank;
    logic                        w_in_accept;
    logic                        w_load_out;
    logic                        w_scan_rd;

    lkvc_kv_store u_store (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .o_key_q  (w_key_q),
        .o_data_q (w_data_q)
    );

    assign w_in_accept = i_valid && o_ready;
    assign w_load_out  = (r_state == lkvc_pkg::ST_RESP) && (!r_out_valid || i_ready);
    assign w_scan_rd   = r_cnt < lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
    assign w_hit_rank  = r_rec[r_hit_idx];

    // capacity zero acts as one, above the store size saturates
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = lkvc_pkg::CNT_W'(1);
        end else if (int'(r_cap) > lkvc_pkg::ENTRIES) begin
            w_eff_cap = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
        end else begin
            w_eff_cap = lkvc_pkg::CNT_W'(r_cap);
        end
    end

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = lkvc_pkg::IDX_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkvc_pkg::ST_IDLE: begin
                if (i_valid) n_state = lkvc_pkg::ST_SCAN;
            end
            lkvc_pkg::ST_SCAN: begin
                if (!w_scan_rd) n_state = lkvc_pkg::ST_DECIDE;
            end
            lkvc_pkg::ST_DECIDE: begin
                if (r_op == lkvc_pkg::OP_GET) begin
                    n_state = lkvc_pkg::ST_RESP;
                end else if (r_found) begin
                    n_state = lkvc_pkg::ST_IDLE;
                end else begin
                    n_state = lkvc_pkg::ST_INSERT;
                end
            end
            lkvc_pkg::ST_RESP: begin
                if (w_load_out) n_state = lkvc_pkg::ST_IDLE;
            end
            lkvc_pkg::ST_INSERT: n_state = lkvc_pkg::ST_IDLE;
            default:             n_state = lkvc_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready          = (r_state == lkvc_pkg::ST_IDLE);
        w_ctl.key_raddr  = r_cnt[lkvc_pkg::IDX_W-1:0];
        w_ctl.data_raddr = r_hit_idx;
        w_ctl.key_wdata  = r_key;
        w_ctl.data_wdata = r_val;
        w_ctl.key_we     = 1'b0;
        w_ctl.data_we    = 1'b0;
        w_ctl.waddr      = r_hit_idx;
        unique case (r_state)
            lkvc_pkg::ST_DECIDE: begin
                w_ctl.data_we = r_found && (r_op == lkvc_pkg::OP_PUT);
            end
            lkvc_pkg::ST_INSERT: begin
                w_ctl.key_we  = w_free_found;
                w_ctl.data_we = w_free_found;
                w_ctl.waddr   = w_free_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkvc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_vfound    <= 1'b0;
            r_fill      <= '0;
            r_cap       <= lkvc_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rec[i]   <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) r_cap <= i_cfg_wdata;

            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_out_hit   <= r_found;
                r_out_value <= r_found ? w_data_q : lkvc_pkg::MISS_VALUE;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                lkvc_pkg::ST_IDLE: begin
                    if (w_in_accept) begin
                        r_op      <= lkvc_pkg::t_opcode'(i_opcode);
                        r_key     <= i_lookup_key;
                        r_val     <= i_store_value;
                        r_cnt     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_found   <= 1'b0;
                        r_vfound  <= 1'b0;
                    end
                end
                lkvc_pkg::ST_SCAN: begin
                    // read one key per cycle, compare it the cycle after
                    r_cmp_vld <= w_scan_rd;
                    r_cmp_idx <= r_cnt[lkvc_pkg::IDX_W-1:0];
                    if (w_scan_rd) r_cnt <= r_cnt + lkvc_pkg::CNT_W'(1);
                    if (r_cmp_vld && r_valid[r_cmp_idx]) begin
                        if (!r_found && (w_key_q == r_key)) begin
                            r_found   <= 1'b1;
                            r_hit_idx <= r_cmp_idx;
                        end
                        // oldest entry, later index wins a tie
                        if (!r_vfound || (r_rec[r_cmp_idx] >= r_best)) begin
                            r_vfound <= 1'b1;
                            r_victim <= r_cmp_idx;
                            r_best   <= r_rec[r_cmp_idx];
                        end
                    end
                end
                lkvc_pkg::ST_DECIDE: begin
                    if (r_found) begin
                        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                            if (r_valid[i] && (r_rec[i] < w_hit_rank)) begin
                                r_rec[i] <= r_rec[i] + lkvc_pkg::IDX_W'(1);
                            end
                        end
                        r_rec[r_hit_idx] <= '0;
                    end else if ((r_op == lkvc_pkg::OP_PUT) && (r_fill >= w_eff_cap)
                                 && r_vfound) begin
                        r_valid[r_victim] <= 1'b0;
                        r_rec[r_victim]   <= '0;
                        if (r_fill != '0) r_fill <= r_fill - lkvc_pkg::CNT_W'(1);
                    end
                end
                lkvc_pkg::ST_INSERT: begin
                    if (w_free_found) begin
                        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                            if (r_valid[i]) r_rec[i] <= r_rec[i] + lkvc_pkg::IDX_W'(1);
                        end
                        r_valid[w_free_idx] <= 1'b1;
                        r_rec[w_free_idx]   <= '0;
                        r_fill              <= r_fill + lkvc_pkg::CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;

endmodule

// ===== rtl/core/lkvc_checker.sv =====
// lkvc_checker: port-level checks of the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_top.
`timescale 1ns / 1ps

module lkvc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic                               o_hit,
    input logic signed [lkvc_pkg::DATA_W-1:0] o_read_value
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit) && $stable(o_read_value))
        else $error("result changed while stalled");

    // a miss always reports all ones
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_read_value == lkvc_pkg::MISS_VALUE)
        else $error("miss without all-ones value");

    // one transaction at a time: busy right after accepting
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after an input transaction");

    // while the scan runs the block stays busy and shows no new result
    a_busy_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> ##4 !o_ready && !$rose(o_valid))
        else $error("scan finished too early");

    // no result straight out of reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_hit        (o_hit),
    .o_read_value (o_read_value)
);
